// ----- src/double_hash_table_engine_assert.svh -----
// Assertion macros for the double hash table engine.
// Uses clk and arst_n of the module that includes it.
`ifndef DOUBLE_HASH_TABLE_ENGINE_ASSERT_SVH
`define DOUBLE_HASH_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define DHTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DHTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define DHTE_ASSERT(lbl, prop, msg)
`define DHTE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/dhte_pkg.sv -----
// Shared types and codes of the double hash table engine.
// No dependencies.
package dhte_pkg;

	localparam int KEY_W  = 31;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 11;

	localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;
	localparam logic [CFG_W-1:0] DIV_RESET = 11'd1021;

	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_DIVISOR  = 1'b1;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] RES_OK        = 2'd0;
	localparam logic [STAT_W-1:0] RES_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] RES_FULL      = 2'd2;

	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_USED  = 2'd1;
	localparam logic [1:0] SLOT_GONE  = 2'd2;

	typedef enum logic [1:0] {
		DSEL_HOME,
		DSEL_STEP,
		DSEL_WRAP
	} dsel_t;

	typedef struct packed {
		logic  clear;
		logic  take_item;
		logic  div_start;
		dsel_t start_sel;
		logic  home_store;
		logic  wrap_store;
		logic  rd;
		logic  check;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_busy;
		logic bad_func;
		logic fin;
	} sts_t;

endpackage

// ----- src/dhte_if.sv -----
// Request and response channel interfaces of the double hash table engine.
// Depends on dhte_pkg.
interface dhte_req_if #(parameter int VALUE_WIDTH = 32);
	import dhte_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [FUNC_W-1:0]      func;
	logic [KEY_W-1:0]       key;
	logic [VALUE_WIDTH-1:0] value;
	modport source (output valid, func, key, value, input ready);
	modport sink (input valid, func, key, value, output ready);
endinterface

interface dhte_rsp_if #(parameter int VALUE_WIDTH = 32);
	import dhte_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [STAT_W-1:0]      status;
	logic [VALUE_WIDTH-1:0] value_out;
	modport source (output valid, status, value_out, input ready);
	modport sink (input valid, status, value_out, output ready);
endinterface

// ----- src/dhte_rem.sv -----
// Bit-serial remainder unit: key-wide dividend by an 11-bit divisor.
// Depends on dhte_pkg.
module dhte_rem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dhte_pkg::KEY_W-1:0] dividend,
	input  logic [dhte_pkg::CFG_W-1:0] divisor,
	output logic                       busy,
	output logic [dhte_pkg::CFG_W-1:0] rem
);
	import dhte_pkg::*;

	localparam int NW = $clog2(KEY_W);

	logic             busy_q;
	logic [NW-1:0]    cnt_q;
	logic [KEY_W-1:0] num_q;
	logic [CFG_W-1:0] div_q;
	logic [CFG_W-1:0] rem_q;
	logic [CFG_W:0]   trial;

	assign trial = {rem_q, num_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + NW'(1);
			if (cnt_q == NW'(KEY_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= CFG_W'(trial - {1'b0, div_q});
			end else begin
				rem_q <= trial[CFG_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

// ----- src/dhte_dp.sv -----
// Datapath: configuration registers, slot memory, hashing and probe arithmetic.
// Depends on dhte_pkg and dhte_rem.
module dhte_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dhte_pkg::cmd_t               cmd,
	output dhte_pkg::sts_t               sts,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [dhte_pkg::CFG_W-1:0]   cfg_data,
	input  logic [dhte_pkg::FUNC_W-1:0]  func,
	input  logic [dhte_pkg::KEY_W-1:0]   key,
	input  logic [VALUE_WIDTH-1:0]       value,
	output logic [dhte_pkg::STAT_W-1:0]  status,
	output logic [VALUE_WIDTH-1:0]       value_out
);
	import dhte_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = 2 + KEY_W + VALUE_WIDTH;

	logic [CFG_W-1:0]       cap_q;
	logic [CFG_W-1:0]       divr_q;
	logic [CW-1:0]          cap_eff;
	logic [CFG_W-1:0]       cap11;
	logic [CFG_W-1:0]       div_eff;

	logic [AW-1:0]          clr_q;
	logic [FUNC_W-1:0]      func_q;
	logic [KEY_W-1:0]       key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [AW-1:0]          idx_q;
	logic [AW-1:0]          smod_q;
	logic [CW-1:0]          probe_q;
	logic [STAT_W-1:0]      res_status_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic [STAT_W-1:0]      out_status_q;
	logic [VALUE_WIDTH-1:0] out_val_q;

	logic [MW-1:0]          mem [TABLE_DEPTH];
	logic [MW-1:0]          rd_q;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [MW-1:0]          wdata;

	logic [KEY_W-1:0]       div_num;
	logic [CFG_W-1:0]       div_den;
	logic                   div_busy;
	logic [CFG_W-1:0]       div_rem;

	logic [1:0]             rd_st;
	logic [KEY_W-1:0]       rd_key;
	logic [VALUE_WIDTH-1:0] rd_val;
	logic                   last;
	logic                   is_ins;
	logic                   is_ers;
	logic                   match;
	logic                   fin;
	logic                   wr_hit;
	logic [STAT_W-1:0]      nres;
	logic [VALUE_WIDTH-1:0] nval;
	logic [AW:0]            sum;
	logic [AW:0]            capx;
	logic [AW-1:0]          nidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			divr_q <= DIV_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_CAPACITY) begin
				cap_q <= cfg_data;
			end else begin
				divr_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (32'(cap_q) > 32'(TABLE_DEPTH)) begin
			cap_eff = CW'(TABLE_DEPTH);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	assign cap11   = CFG_W'(cap_eff);
	assign div_eff = (divr_q == '0) ? CFG_W'(1) : divr_q;

	always_comb begin
		unique case (cmd.start_sel)
			DSEL_HOME: begin
				div_num = key_q;
				div_den = cap11;
			end
			DSEL_STEP: begin
				div_num = key_q;
				div_den = div_eff;
			end
			DSEL_WRAP: begin
				div_num = KEY_W'(div_eff - div_rem);
				div_den = cap11;
			end
			default: begin
				div_num = key_q;
				div_den = cap11;
			end
		endcase
	end

	dhte_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.rem      (div_rem)
	);

	assign rd_st  = rd_q[MW-1 -: 2];
	assign rd_key = rd_q[VALUE_WIDTH +: KEY_W];
	assign rd_val = rd_q[VALUE_WIDTH-1:0];
	assign last   = (probe_q == CW'(cap_eff - CW'(1)));
	assign is_ins = (func_q == FUNC_INSERT);
	assign is_ers = (func_q == FUNC_ERASE);
	assign match  = (rd_st == SLOT_USED) && (rd_key == key_q);

	always_comb begin
		fin    = 1'b0;
		wr_hit = 1'b0;
		nres   = res_status_q;
		nval   = res_val_q;
		if (is_ins) begin
			if (rd_st != SLOT_USED) begin
				fin    = 1'b1;
				wr_hit = 1'b1;
				nres   = RES_OK;
			end else if (last) begin
				fin  = 1'b1;
				nres = RES_FULL;
			end
		end else begin
			if (rd_st == SLOT_EMPTY) begin
				fin = 1'b1;
			end else if (match) begin
				fin  = 1'b1;
				nres = RES_OK;
				if (is_ers) begin
					wr_hit = 1'b1;
				end else begin
					nval = rd_val;
				end
			end else if (last) begin
				fin = 1'b1;
			end
		end
	end

	assign sum  = {1'b0, idx_q} + {1'b0, smod_q};
	assign capx = (AW + 1)'(cap_eff);
	assign nidx = (sum >= capx) ? AW'(sum - capx) : AW'(sum);

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {SLOT_USED, key_q, val_q};
		if (cmd.clear) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = {SLOT_EMPTY, key_q, val_q};
		end else if (cmd.check && wr_hit) begin
			we = 1'b1;
			if (!is_ins) begin
				wdata = {SLOT_GONE, rd_key, rd_val};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			func_q       <= func;
			key_q        <= key;
			val_q        <= value;
			res_status_q <= RES_NOT_FOUND;
			res_val_q    <= '0;
		end
		if (cmd.home_store) begin
			idx_q   <= AW'(div_rem);
			probe_q <= '0;
		end
		if (cmd.wrap_store) begin
			smod_q <= AW'(div_rem);
		end
		if (cmd.check) begin
			if (fin) begin
				res_status_q <= nres;
				res_val_q    <= nval;
			end else begin
				idx_q   <= nidx;
				probe_q <= probe_q + CW'(1);
			end
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
		end
	end

	assign sts.clr_last = (clr_q == AW'(TABLE_DEPTH - 1));
	assign sts.div_busy = div_busy;
	assign sts.bad_func = !(is_ins || is_ers || (func_q == FUNC_LOOKUP));
	assign sts.fin      = fin;

	assign status    = out_status_q;
	assign value_out = out_val_q;

endmodule

// ----- src/dhte_ctrl.sv -----
// Controller state machine: clearing pass, hash phases, probe loop, result hand-off.
// Depends on dhte_pkg and double_hash_table_engine_assert.svh.
`include "double_hash_table_engine_assert.svh"
module dhte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  dhte_pkg::sts_t sts,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic           out_ready,
	output logic           out_valid,
	output dhte_pkg::cmd_t cmd
);
	import dhte_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_PREP   = 9'b000000100,
		S_DHOME  = 9'b000001000,
		S_DSTEP  = 9'b000010000,
		S_DWRAP  = 9'b000100000,
		S_READ   = 9'b001000000,
		S_CHECK  = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign req_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.take_item = 1'b1;
					state_d       = S_PREP;
				end
			end
			S_PREP: begin
				if (sts.bad_func) begin
					state_d = S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					cmd.start_sel = DSEL_HOME;
					state_d       = S_DHOME;
				end
			end
			S_DHOME: begin
				if (!sts.div_busy) begin
					cmd.home_store = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.start_sel  = DSEL_STEP;
					state_d        = S_DSTEP;
				end
			end
			S_DSTEP: begin
				if (!sts.div_busy) begin
					cmd.div_start = 1'b1;
					cmd.start_sel = DSEL_WRAP;
					state_d       = S_DWRAP;
				end
			end
			S_DWRAP: begin
				if (!sts.div_busy) begin
					cmd.wrap_store = 1'b1;
					state_d        = S_READ;
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.fin ? S_FINISH : S_READ;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DHTE_ASSERT(a_check_after_read, (state_q == S_CHECK) |-> $past(state_q == S_READ), "check without read")
	`DHTE_ASSERT_NEXT(a_finish_loads, (state_q == S_FINISH) && out_free, out_valid_q && (state_q == S_IDLE), "result not handed off")
	`DHTE_ASSERT_NEXT(a_result_held, out_valid_q && !out_ready, out_valid_q, "waiting result dropped")

endmodule

// ----- src/double_hash_table_engine.sv -----
// Double hash table engine top level. Depends on dhte_pkg, dhte_if, dhte_ctrl, dhte_dp.
// After reset a clearing pass empties the slot table; no item is taken.
// Per item: a capture, three serial remainders, then a read and a check per probe for
// p probes (1 to capacity), then a hand-off; an item with a bad function skips to the hand-off.
// One item is in flight at a time.
module double_hash_table_engine #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	dhte_req_if.sink                   req,
	dhte_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [dhte_pkg::CFG_W-1:0] cfg_data
);
	import dhte_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dhte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.cmd       (cmd)
	);

	dhte_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.func      (req.func),
		.key       (req.key),
		.value     (req.value),
		.status    (rsp.status),
		.value_out (rsp.value_out)
	);

endmodule

// ----- dv/tb_double_hash_table_engine.sv -----
// Self-checking testbench of the double hash table engine: random and directed
// insert, erase and lookup transactions against an in-bench slot table predictor.
// Depends on dhte_pkg, dhte_if and double_hash_table_engine.
module tb_double_hash_table_engine;
	import dhte_pkg::*;

	localparam int DEPTH     = 1024;
	localparam int VW        = 32;
	localparam int LIMIT     = 20000000;
	localparam int HOLD_LEN  = 3000;
	localparam int HOLD_AT   = 400;
	localparam int NPHASE    = 12;

	localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;

	class hash_table_scoreboard;
		logic [1:0]    slot_st [DEPTH];
		logic [KEY_W-1:0] slot_k [DEPTH];
		logic [VW-1:0] slot_v [DEPTH];
		logic [CFG_W-1:0] cap_reg;
		logic [CFG_W-1:0] div_reg;
		logic [STAT_W-1:0] exp_status [$];
		logic [VW-1:0] exp_value [$];
		int errors;

		function new();
			foreach (slot_st[i]) slot_st[i] = SLOT_EMPTY;
			cap_reg = CAP_RESET;
			div_reg = DIV_RESET;
			errors  = 0;
		endfunction

		function void set_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == REG_CAPACITY) cap_reg = data;
			else div_reg = data;
		endfunction

		function void note_item(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [VW-1:0] v);
			int unsigned cap, dv, stp, idx;
			logic [STAT_W-1:0] st;
			logic [VW-1:0] vo;
			cap = cap_reg;
			if (cap == 0) cap = 1;
			if (cap > DEPTH) cap = DEPTH;
			dv = (div_reg == 0) ? 1 : div_reg;
			stp = dv - (32'(k) % dv);
			idx = 32'(k) % cap;
			st = RES_NOT_FOUND;
			vo = '0;
			if (f == FUNC_INSERT) begin
				st = RES_FULL;
				for (int p = 0; p < cap; p++) begin
					if (slot_st[idx] != SLOT_USED) begin
						slot_st[idx] = SLOT_USED;
						slot_k[idx] = k;
						slot_v[idx] = v;
						st = RES_OK;
						break;
					end
					idx = (idx + stp) % cap;
				end
			end else if (f == FUNC_ERASE || f == FUNC_LOOKUP) begin
				for (int p = 0; p < cap; p++) begin
					if (slot_st[idx] == SLOT_EMPTY) break;
					if (slot_st[idx] == SLOT_USED && slot_k[idx] == k) begin
						if (f == FUNC_ERASE) slot_st[idx] = SLOT_GONE;
						else vo = slot_v[idx];
						st = RES_OK;
						break;
					end
					idx = (idx + stp) % cap;
				end
			end
			exp_status.push_back(st);
			exp_value.push_back(vo);
		endfunction

		function void check_result(logic [STAT_W-1:0] st, logic [VW-1:0] vo);
			logic [STAT_W-1:0] es;
			logic [VW-1:0] ev;
			if (exp_status.size() == 0) begin
				$error("unexpected result status=%0d value_out=%h", st, vo);
				errors++;
				return;
			end
			es = exp_status.pop_front();
			ev = exp_value.pop_front();
			if (st !== es) begin
				$error("status expected %0d actual %0d", es, st);
				errors++;
			end
			if (vo !== ev) begin
				$error("value_out expected %h actual %h", ev, vo);
				errors++;
			end
		endfunction

		function int pending();
			return exp_status.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	int cycles = 0;
	int sent = 0;
	bit quiet = 1'b0;

	dhte_req_if #(VW) req_ch ();
	dhte_rsp_if #(VW) rsp_ch ();

	hash_table_scoreboard sb = new();

	double_hash_table_engine #(.TABLE_DEPTH(DEPTH), .VALUE_WIDTH(VW)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 250 == 0) quiet <= ($urandom_range(0, 3) == 0);
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	// response side: random back-pressure plus one long hold-off
	initial begin
		int hold;
		bit held;
		held = 1'b0;
		hold = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				hold = HOLD_LEN;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (pick_gap() == 0);
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.status, rsp_ch.value_out);
		end
	end

	task automatic send(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [VW-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.key <= k;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_item(f, k, v);
		sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic random_phase(int cap, int n);
		logic [KEY_W-1:0] pool [12];
		logic [KEY_W-1:0] k;
		logic [FUNC_W-1:0] f;
		int r;
		foreach (pool[i])
			pool[i] = (i < 6) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 4 * cap + 3));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			k = pool[$urandom_range(0, 11)];
			if (r < 40) f = FUNC_INSERT;
			else if (r < 65) f = FUNC_LOOKUP;
			else if (r < 90) f = FUNC_ERASE;
			else if (r < 96) begin
				f = FUNC_LOOKUP;
				k = KEY_W'($urandom);
			end else f = FUNC_BAD;
			send(f, k, $urandom);
		end
	endtask

	initial begin
		int caps [NPHASE] = '{0, 2047, 1, 8, 16, 4, 16, 1024, 2, 64, 1024, 11};
		int divs [NPHASE] = '{0, 2047, 1, 5, 7, 3, 7, 1024, 1, 61, 1021, 13};
		int cnts [NPHASE] = '{80, 60, 60, 200, 200, 120, 150, 60, 100, 220, 60, 140};
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_INSERT;
		req_ch.key <= '0;
		req_ch.value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (DEPTH + 16) @(posedge clk);

		send(FUNC_LOOKUP, 31'd5, 32'h0);
		send(FUNC_INSERT, 31'd0, 32'h0);
		send(FUNC_INSERT, 31'h7FFFFFFF, 32'hFFFFFFFF);
		send(FUNC_LOOKUP, 31'd0, 32'h1234);
		send(FUNC_LOOKUP, 31'h7FFFFFFF, 32'h0);
		send(FUNC_INSERT, 31'd0, 32'h1);
		send(FUNC_LOOKUP, 31'd0, 32'h0);
		send(FUNC_ERASE, 31'd0, 32'h0);
		send(FUNC_LOOKUP, 31'd0, 32'h0);
		send(FUNC_INSERT, 31'd0, 32'hA5A5A5A5);
		send(FUNC_LOOKUP, 31'd0, 32'h0);
		send(FUNC_ERASE, 31'd77, 32'h0);
		send(FUNC_BAD, 31'd0, 32'hFFFFFFFF);
		send(FUNC_INSERT, 31'd1024, 32'h5A5A5A5A);
		send(FUNC_LOOKUP, 31'd1024, 32'h0);
		send(FUNC_ERASE, 31'h7FFFFFFF, 32'h0);
		send(FUNC_LOOKUP, 31'h7FFFFFFF, 32'h0);
		send(FUNC_ERASE, 31'd1024, 32'h0);
		send(FUNC_LOOKUP, 31'd1024, 32'h0);
		random_phase(DEPTH, 80);

		for (int ph = 0; ph < NPHASE; ph++) begin
			drain();
			write_reg(REG_CAPACITY, CFG_W'(caps[ph]));
			write_reg(REG_DIVISOR, CFG_W'(divs[ph]));
			cfg_we <= 1'b0;
			random_phase((caps[ph] == 0) ? 1 : ((caps[ph] > DEPTH) ? DEPTH : caps[ph]), cnts[ph]);
		end
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
